// ===== hw/rtl/ostt_pkg.sv =====
// Shared types and constants for the one-shot timeout timer.
// No dependencies; every other file of the block refers to it by scoped names.
package ostt_pkg;

    localparam int TICKS_W = 24;

    localparam logic [TICKS_W-1:0] MAX_TIMEOUT_RESET = {TICKS_W{1'b1}};

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_ARM       = 2'd1,
        OP_ARM_NEVER = 2'd2,
        OP_QUERY     = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t              opcode;
        logic [TICKS_W-1:0]   duration_ticks;
    } cmd_t;

    typedef struct packed {
        logic                 expired;
        logic                 never_expires;
        logic [TICKS_W-1:0]   remaining_ticks;
        logic                 elapsed_valid;
        logic [TICKS_W-1:0]   elapsed_ticks;
    } rsp_t;

endpackage

// ===== hw/rtl/ostt_cmd_if.sv =====
// Command channel of the one-shot timeout timer: valid/ready plus payload.
// Depends on ostt_pkg for the opcode type and field width.
interface ostt_cmd_if;
    logic                          valid;
    logic                          ready;
    ostt_pkg::opcode_t             opcode;
    logic [ostt_pkg::TICKS_W-1:0]  duration_ticks;

    modport source (output valid, output opcode, output duration_ticks, input ready);
    modport sink   (input valid, input opcode, input duration_ticks, output ready);
endinterface

// ===== hw/rtl/ostt_rsp_if.sv =====
// Response channel of the one-shot timeout timer: valid/ready plus payload.
// Depends on ostt_pkg for the field width.
interface ostt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          expired;
    logic                          never_expires;
    logic [ostt_pkg::TICKS_W-1:0]  remaining_ticks;
    logic                          elapsed_valid;
    logic [ostt_pkg::TICKS_W-1:0]  elapsed_ticks;

    modport source (output valid, output expired, output never_expires,
                    output remaining_ticks, output elapsed_valid,
                    output elapsed_ticks, input ready);
    modport sink   (input valid, input expired, input never_expires,
                    input remaining_ticks, input elapsed_valid,
                    input elapsed_ticks, output ready);
endinterface

// ===== hw/rtl/ostt_cmd_reg.sv =====
// Input register of the one-shot timeout timer: captures one command.
// Depends on ostt_pkg (cmd_t).
module ostt_cmd_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ostt_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_take,
    output ostt_pkg::cmd_t out_cmd
);

    logic           valid_reg;
    logic           valid_next;
    ostt_pkg::cmd_t cmd_reg;

    assign in_ready   = !valid_reg || out_take;
    assign valid_next = (valid_reg && !out_take) || in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= in_cmd;
        end
    end

    assign out_valid = valid_reg;
    assign out_cmd   = cmd_reg;

endmodule

// ===== hw/rtl/ostt_core.sv =====
// Timer state and single-pass execution of one command per cycle while exec is high.
// Holds tick counter, timer mode, start/deadline and the max timeout register.
// Depends on ostt_pkg (cmd_t, rsp_t, opcode_t).
module ostt_core #(
    parameter longint unsigned WRAP_COUNT = 64'd16777216
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          exec,
    input  ostt_pkg::cmd_t                cmd,
    input  logic                          cfg_we,
    input  logic [ostt_pkg::TICKS_W-1:0]  cfg_wdata,
    output ostt_pkg::rsp_t                rsp
);

    localparam int TICK_W = (WRAP_COUNT > 64'd1) ? $clog2(WRAP_COUNT) : 1;
    localparam int CALC_W = ((TICK_W > ostt_pkg::TICKS_W) ? TICK_W : ostt_pkg::TICKS_W) + 1;
    localparam logic [CALC_W-1:0] WRAP_EXT = CALC_W'(WRAP_COUNT);
    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(WRAP_COUNT - 64'd1);

    typedef enum logic [1:0] {
        MODE_UNINIT = 2'd0,
        MODE_NEVER  = 2'd1,
        MODE_ACTIVE = 2'd2,
        MODE_DONE   = 2'd3
    } mode_t;

    logic [ostt_pkg::TICKS_W-1:0] max_reg;
    logic [TICK_W-1:0]            tick_reg;
    logic [TICK_W-1:0]            tick_next;
    mode_t                        mode_reg;
    mode_t                        mode_next;
    logic [TICK_W-1:0]            start_reg;
    logic [TICK_W-1:0]            start_next;
    logic [CALC_W-1:0]            deadline_reg;
    logic [CALC_W-1:0]            deadline_next;

    logic [CALC_W-1:0]            tick_ext;
    logic [CALC_W-1:0]            now;
    logic [CALC_W-1:0]            since_start;
    logic [CALC_W-1:0]            to_deadline;
    logic [ostt_pkg::TICKS_W-1:0] dur_clamped;
    logic                         past_deadline;

    // Time is unwrapped against the start tick: a tick below start has wrapped.
    assign tick_ext      = CALC_W'(tick_reg);
    assign now           = tick_ext + ((tick_reg < start_reg) ? WRAP_EXT : '0);
    assign since_start   = now - CALC_W'(start_reg);
    assign to_deadline   = deadline_reg - now;
    assign past_deadline = (now >= deadline_reg);
    assign dur_clamped   = (cmd.duration_ticks > max_reg) ? max_reg : cmd.duration_ticks;

    always_comb
    begin
        tick_next     = tick_reg;
        mode_next     = mode_reg;
        start_next    = start_reg;
        deadline_next = deadline_reg;
        case (cmd.opcode)
            ostt_pkg::OP_TICK:
            begin
                tick_next = (tick_reg == TICK_LAST) ? '0 : tick_reg + TICK_W'(1);
            end
            ostt_pkg::OP_ARM:
            begin
                mode_next     = MODE_ACTIVE;
                start_next    = tick_reg;
                deadline_next = tick_ext + CALC_W'(dur_clamped);
            end
            ostt_pkg::OP_ARM_NEVER:
            begin
                mode_next  = MODE_NEVER;
                start_next = tick_reg;
            end
            ostt_pkg::OP_QUERY:
            begin
                if (mode_reg == MODE_UNINIT || (mode_reg == MODE_ACTIVE && past_deadline))
                begin
                    mode_next = MODE_DONE;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_comb
    begin
        rsp.expired         = (mode_reg == MODE_UNINIT) || (mode_reg == MODE_DONE)
                              || (mode_reg == MODE_ACTIVE && past_deadline);
        rsp.never_expires   = (mode_reg == MODE_NEVER);
        rsp.remaining_ticks = (mode_reg == MODE_ACTIVE && !past_deadline)
                              ? to_deadline[ostt_pkg::TICKS_W-1:0] : '0;
        rsp.elapsed_valid   = (mode_reg != MODE_UNINIT);
        rsp.elapsed_ticks   = (mode_reg != MODE_UNINIT)
                              ? since_start[ostt_pkg::TICKS_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg      <= ostt_pkg::MAX_TIMEOUT_RESET;
            tick_reg     <= '0;
            mode_reg     <= MODE_UNINIT;
            start_reg    <= '0;
            deadline_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_reg <= cfg_wdata;
            end
            if (exec)
            begin
                tick_reg     <= tick_next;
                mode_reg     <= mode_next;
                start_reg    <= start_next;
                deadline_reg <= deadline_next;
            end
        end
    end

endmodule

// ===== hw/rtl/ostt_rsp_reg.sv =====
// Result register of the one-shot timeout timer: holds one query response.
// Depends on ostt_pkg (rsp_t).
module ostt_rsp_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  ostt_pkg::rsp_t in_rsp,
    output logic           can_load,
    output logic           out_valid,
    input  logic           out_ready,
    output ostt_pkg::rsp_t out_rsp
);

    logic           valid_reg;
    ostt_pkg::rsp_t rsp_reg;

    assign can_load = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            rsp_reg <= in_rsp;
        end
    end

    assign out_valid = valid_reg;
    assign out_rsp   = rsp_reg;

endmodule

// ===== hw/rtl/one_shot_timeout_timer_unit.sv =====
// One-shot timeout timer on a wrapping tick counter. Every command transaction
// lands in a command register; from there the timer core executes it in one
// pass (tick, arm, arm-never or query) and a query writes its response into
// the result register, so a query passes the command register and then the
// result register before its response is valid. The block sustains one
// command per cycle while no response stalls: the only loop is the
// update of the timer state, and the result register lets the
// next command execute while an earlier response still waits. A stalled
// response only stops another query from executing; that stall then backs up
// into the command register. The tick counter runs 0..WRAP_COUNT-1; elapsed
// and remaining ticks are reported modulo 2^24. max_timeout_ticks (reset all
// ones) clamps armed durations and is written through cfg_we/cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
// Depends on ostt_pkg, ostt_cmd_if, ostt_rsp_if, ostt_cmd_reg, ostt_core, ostt_rsp_reg.
module one_shot_timeout_timer_unit #(
    parameter longint unsigned WRAP_COUNT = 64'd16777216
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ostt_cmd_if.sink                      cmd,
    ostt_rsp_if.source                    rsp,
    input  logic                          cfg_we,
    input  logic [ostt_pkg::TICKS_W-1:0]  cfg_wdata
);

    ostt_pkg::cmd_t cmd_in;
    ostt_pkg::cmd_t cmd_q;
    logic           cmd_valid_q;
    logic           advance;
    logic           rsp_load;
    logic           rsp_can_load;
    ostt_pkg::rsp_t core_rsp;
    ostt_pkg::rsp_t rsp_q;

    assign cmd_in.opcode         = cmd.opcode;
    assign cmd_in.duration_ticks = cmd.duration_ticks;

    ostt_cmd_reg u_cmd_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .in_cmd    (cmd_in),
        .out_valid (cmd_valid_q),
        .out_take  (advance),
        .out_cmd   (cmd_q)
    );

    // Non-query commands never wait; a query waits only for the result slot.
    assign advance  = cmd_valid_q && ((cmd_q.opcode != ostt_pkg::OP_QUERY) || rsp_can_load);
    assign rsp_load = advance && (cmd_q.opcode == ostt_pkg::OP_QUERY);

    ostt_core #(
        .WRAP_COUNT (WRAP_COUNT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .exec      (advance),
        .cmd       (cmd_q),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp       (core_rsp)
    );

    ostt_rsp_reg u_rsp_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (rsp_load),
        .in_rsp    (core_rsp),
        .can_load  (rsp_can_load),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_rsp   (rsp_q)
    );

    assign rsp.expired         = rsp_q.expired;
    assign rsp.never_expires   = rsp_q.never_expires;
    assign rsp.remaining_ticks = rsp_q.remaining_ticks;
    assign rsp.elapsed_valid   = rsp_q.elapsed_valid;
    assign rsp.elapsed_ticks   = rsp_q.elapsed_ticks;

    // An executed query always shows up as a response on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) rsp_load |=> rsp.valid)
        else $error("executed query produced no response");

    // A response that is still pending is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |-> (!rsp.valid || rsp.ready))
        else $error("response overwritten while stalled");

    // Commands back up only when a held command could not execute.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (cmd_valid_q && !advance))
        else $error("command port stalled without a blocked command");

    // An expired response never reports remaining time or never-expire.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.expired) |-> (rsp.remaining_ticks == '0 && !rsp.never_expires))
        else $error("expired response carries remaining ticks");

endmodule

// ===== test/one_shot_timeout_timer_unit_test.sv =====
// Self-checking testbench for the one-shot timeout timer unit.
// Needs ostt_pkg, ostt_cmd_if, ostt_rsp_if and the RTL of one_shot_timeout_timer_unit.
module one_shot_timeout_timer_unit_test;

    // Same wrap as the block's default.
    localparam longint unsigned TB_WRAP_COUNT = 64'd16777216;
    // Drain wait that lets non-query commands still in the pipe retire.
    localparam int DRAIN_CYCLES = 4;
    localparam int RSP_HOLD_CYCLES = 300;
    localparam int STORM_QUERIES = 40;
    localparam int PHASE_ITEMS = 330;

    typedef enum logic [1:0] {
        MODE_UNINIT = 2'd0,
        MODE_NEVER  = 2'd1,
        MODE_ACTIVE = 2'd2,
        MODE_DONE   = 2'd3
    } timer_mode_t;

    // Mirror of the timer state plus the queue of responses it predicts.
    class timer_mirror;
        longint unsigned              wrap;
        logic [ostt_pkg::TICKS_W-1:0] max_ticks;
        longint unsigned              tick_now;
        longint unsigned              start_at;
        longint unsigned              deadline;
        timer_mode_t                  mode;
        ostt_pkg::rsp_t               pending_rsp[$];
        int                           errors;

        function new(longint unsigned wrap_count);
            wrap      = wrap_count;
            max_ticks = ostt_pkg::MAX_TIMEOUT_RESET;
            tick_now  = 0;
            start_at  = 0;
            deadline  = 0;
            mode      = MODE_UNINIT;
            errors    = 0;
        endfunction

        // Advance the mirror by one accepted command transaction.
        function void apply_cmd(ostt_pkg::opcode_t op, logic [ostt_pkg::TICKS_W-1:0] dur);
            longint unsigned              now;
            longint unsigned              diff;
            logic [ostt_pkg::TICKS_W-1:0] clamped;
            ostt_pkg::rsp_t               r;
            r = '0;
            case (op)
                ostt_pkg::OP_TICK:
                begin
                    tick_now++;
                    if (tick_now >= wrap)
                        tick_now = 0;
                end
                ostt_pkg::OP_ARM:
                begin
                    clamped  = (dur > max_ticks) ? max_ticks : dur;
                    mode     = MODE_ACTIVE;
                    start_at = tick_now;
                    deadline = tick_now + clamped;
                end
                ostt_pkg::OP_ARM_NEVER:
                begin
                    // deadline is left as it was
                    mode     = MODE_NEVER;
                    start_at = tick_now;
                end
                default:
                begin
                    if (mode != MODE_UNINIT)
                    begin
                        r.elapsed_valid = 1'b1;
                        if (tick_now >= start_at)
                            diff = tick_now - start_at;
                        else
                            diff = tick_now + wrap - start_at;
                        r.elapsed_ticks = diff[ostt_pkg::TICKS_W-1:0];
                    end
                    // a never-armed timer is reported expired and stays done
                    if (mode == MODE_UNINIT)
                        mode = MODE_DONE;
                    if (mode == MODE_DONE)
                        r.expired = 1'b1;
                    else if (mode == MODE_NEVER)
                        r.never_expires = 1'b1;
                    else
                    begin
                        now = tick_now;
                        if (now < start_at)
                            now += wrap;
                        if (now >= deadline)
                        begin
                            mode      = MODE_DONE;
                            r.expired = 1'b1;
                        end
                        else
                        begin
                            diff              = deadline - now;
                            r.remaining_ticks = diff[ostt_pkg::TICKS_W-1:0];
                        end
                    end
                    pending_rsp.push_back(r);
                end
            endcase
        endfunction

        function void compare_field(string name, longint unsigned exp_v,
                                    longint unsigned got_v);
            if (exp_v != got_v)
            begin
                $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        // Check one accepted response against the oldest prediction.
        function void check_rsp(ostt_pkg::rsp_t got);
            ostt_pkg::rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                $error("response transaction with no prediction pending");
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            compare_field("expired", want.expired, got.expired);
            compare_field("never_expires", want.never_expires, got.never_expires);
            compare_field("remaining_ticks", want.remaining_ticks, got.remaining_ticks);
            compare_field("elapsed_valid", want.elapsed_valid, got.elapsed_valid);
            compare_field("elapsed_ticks", want.elapsed_ticks, got.elapsed_ticks);
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [ostt_pkg::TICKS_W-1:0] cfg_wdata;

    ostt_cmd_if cmd_ch();
    ostt_rsp_if rsp_ch();

    timer_mirror mirror = new(TB_WRAP_COUNT);

    // Upper bound of the per-transaction idle draw, shared by both sides.
    // Zero gives stretches with back-to-back traffic.
    int max_gap = 8;
    // Raised by the stimulus to make the response side stall for a long time.
    bit rsp_hold_req = 1'b0;

    one_shot_timeout_timer_unit #(
        .WRAP_COUNT (TB_WRAP_COUNT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Offer one command; returns at the edge where it is accepted.
    // valid stays high on return so a zero-gap follow-up needs no toggle.
    task automatic send_cmd(ostt_pkg::opcode_t op, logic [ostt_pkg::TICKS_W-1:0] dur);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.opcode         <= op;
        cmd_ch.duration_ticks <= dur;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        mirror.apply_cmd(op, dur);
    endtask

    // Stop offering and wait until every predicted response is back, then
    // give non-query commands still in flight time to retire.
    task automatic drain_block();
        cmd_ch.valid <= 1'b0;
        while (mirror.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Only called while the block is drained.
    task automatic set_max_timeout(logic [ostt_pkg::TICKS_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        mirror.max_ticks = value;
    endtask

    task automatic run_random(int count);
        ostt_pkg::opcode_t            op;
        logic [ostt_pkg::TICKS_W-1:0] dur;
        int                           pick;
        for (int i = 0; i < count; i++)
        begin
            // switch the idling profile every 40 transactions
            if (i % 40 == 0)
                max_gap = ($urandom_range(0, 3) == 0) ? 0 : 8;
            pick = $urandom_range(0, 99);
            if (pick < 45)
                op = ostt_pkg::OP_TICK;
            else if (pick < 62)
                op = ostt_pkg::OP_ARM;
            else if (pick < 67)
                op = ostt_pkg::OP_ARM_NEVER;
            else
                op = ostt_pkg::OP_QUERY;
            // mostly short timeouts so they expire, some huge or clamped ones
            case ($urandom_range(0, 9))
                0:       dur = '0;
                1:       dur = '1;
                2:       dur = ostt_pkg::TICKS_W'($urandom);
                3:       dur = mirror.max_ticks
                               + ostt_pkg::TICKS_W'($urandom_range(0, 2)) - 1'b1;
                default: dur = ostt_pkg::TICKS_W'($urandom_range(0, 60));
            endcase
            // ignored field still gets random bits on non-arm commands
            if (op != ostt_pkg::OP_ARM && $urandom_range(0, 1) == 1)
                dur = ostt_pkg::TICKS_W'($urandom);
            send_cmd(op, dur);
        end
    endtask

    // Response side: random stalls, an occasional long hold, checks each
    // accepted response transaction.
    initial
    begin
        int             gap;
        ostt_pkg::rsp_t got;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rsp_hold_req)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(posedge clk);
                rsp_hold_req = 1'b0;
            end
            gap = $urandom_range(0, max_gap);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            got.expired         = rsp_ch.expired;
            got.never_expires   = rsp_ch.never_expires;
            got.remaining_ticks = rsp_ch.remaining_ticks;
            got.elapsed_valid   = rsp_ch.elapsed_valid;
            got.elapsed_ticks   = rsp_ch.elapsed_ticks;
            mirror.check_rsp(got);
        end
    end

    // Main stimulus.
    initial
    begin
        logic [ostt_pkg::TICKS_W-1:0] phase_max[6];
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= '0;
        cmd_ch.valid          <= 1'b0;
        cmd_ch.opcode         <= ostt_pkg::OP_TICK;
        cmd_ch.duration_ticks <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: never-armed query, done timer, zero duration, countdown
        // to expiry, never-expiring timer, largest duration.
        send_cmd(ostt_pkg::OP_QUERY, '0);
        send_cmd(ostt_pkg::OP_QUERY, '1);
        send_cmd(ostt_pkg::OP_TICK, '0);
        send_cmd(ostt_pkg::OP_TICK, '1);
        send_cmd(ostt_pkg::OP_QUERY, '0);
        send_cmd(ostt_pkg::OP_ARM, 24'd0);
        send_cmd(ostt_pkg::OP_QUERY, '0);
        send_cmd(ostt_pkg::OP_ARM, 24'd5);
        send_cmd(ostt_pkg::OP_QUERY, '0);
        repeat (3) send_cmd(ostt_pkg::OP_TICK, '0);
        send_cmd(ostt_pkg::OP_QUERY, '0);
        repeat (2) send_cmd(ostt_pkg::OP_TICK, '0);
        send_cmd(ostt_pkg::OP_QUERY, '0);
        send_cmd(ostt_pkg::OP_QUERY, '0);
        send_cmd(ostt_pkg::OP_ARM_NEVER, '1);
        send_cmd(ostt_pkg::OP_QUERY, '0);
        send_cmd(ostt_pkg::OP_ARM, '1);
        send_cmd(ostt_pkg::OP_QUERY, '0);
        send_cmd(ostt_pkg::OP_TICK, '0);
        send_cmd(ostt_pkg::OP_QUERY, '0);
        drain_block();

        // Clamp at zero, tiny, short, random, full range, random small.
        phase_max[0] = '0;
        phase_max[1] = 24'd1;
        phase_max[2] = 24'd37;
        phase_max[3] = ostt_pkg::TICKS_W'($urandom);
        phase_max[4] = '1;
        phase_max[5] = ostt_pkg::TICKS_W'($urandom_range(0, 100));

        for (int p = 0; p < 6; p++)
        begin
            set_max_timeout(phase_max[p]);
            run_random(PHASE_ITEMS / 2);
            if (p == 2)
            begin
                // Back up the response path: the sink stalls for a long
                // stretch while queries keep coming back to back.
                rsp_hold_req = 1'b1;
                max_gap = 0;
                repeat (STORM_QUERIES)
                    send_cmd(ostt_pkg::OP_QUERY, ostt_pkg::TICKS_W'($urandom));
                max_gap = 8;
            end
            run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            drain_block();
        end

        if (mirror.pending_rsp.size() == 0 && mirror.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
